[design/fpd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpd_pkg: shared definitions for the fractional-N divider calculator
// Register indexes, field widths, reset values, status codes and the
// frequency band table.
// ---------------------------------------------------------------------------
package fpd_pkg;

    localparam int MODULUS_BITS_DEF = 12;

    // Field widths
    localparam int CLK_W   = 28;   // reference clock
    localparam int SPC_W   = 20;   // channel spacing
    localparam int FREQ_W  = 29;   // wanted frequency
    localparam int DIV_W   = 3;    // divider exponent
    localparam int RC_W    = 6;    // reference counter
    localparam int INT_W   = 16;   // integer value
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;    // configuration index
    localparam int CDAT_W  = 28;   // configuration data

    // Derived internal widths
    localparam int PFD_W   = CLK_W + 1;    // reference clock, possibly doubled
    localparam int F10_W   = FREQ_W + 4;   // frequency times ten
    // The band limits keep (freq * 10 << div) * rc below 2^38 for any input.
    localparam int VCO_W   = 38;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_REF_CLOCK = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SPACING   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DOUBLER   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_HALVE     = 2'd3;

    // Reset values
    localparam logic [CLK_W-1:0] RST_REF_CLOCK = 28'd10000000;
    localparam logic [SPC_W-1:0] RST_SPACING   = 20'd100;
    localparam logic             RST_DOUBLER   = 1'b1;
    localparam logic             RST_HALVE     = 1'b0;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_MOD = 2'd1;
    localparam logic [STAT_W-1:0] ST_INT_SAT  = 2'd2;

    localparam logic [INT_W-1:0] INT_MAX = 16'hFFFF;

    // Band thresholds, a band is selected when the frequency lies above its limit
    localparam logic [FREQ_W-1:0] BAND_LIM0 = 29'd220000000;
    localparam logic [FREQ_W-1:0] BAND_LIM1 = 29'd110000000;
    localparam logic [FREQ_W-1:0] BAND_LIM2 = 29'd55000000;
    localparam logic [FREQ_W-1:0] BAND_LIM3 = 29'd27500000;
    localparam logic [FREQ_W-1:0] BAND_LIM4 = 29'd13750000;
    localparam logic [FREQ_W-1:0] BAND_LIM5 = 29'd6875000;

    typedef struct packed {
        logic [CLK_W-1:0] ref_clock_hz;
        logic [SPC_W-1:0] channel_spacing_hz;
        logic             ref_doubler;
        logic             ref_halve;
    } t_cfg;

    typedef struct packed {
        logic [DIV_W-1:0] div;
        logic [RC_W-1:0]  rc;
    } t_band;

    function automatic t_band band_sel(input logic [FREQ_W-1:0] freq);
        t_band b;
        if (freq > BAND_LIM0) begin
            b.div = 3'd0; b.rc = 6'd50;
        end else if (freq > BAND_LIM1) begin
            b.div = 3'd1; b.rc = 6'd25;
        end else if (freq > BAND_LIM2) begin
            b.div = 3'd2; b.rc = 6'd16;
        end else if (freq > BAND_LIM3) begin
            b.div = 3'd3; b.rc = 6'd8;
        end else if (freq > BAND_LIM4) begin
            b.div = 3'd4; b.rc = 6'd4;
        end else if (freq > BAND_LIM5) begin
            b.div = 3'd5; b.rc = 6'd2;
        end else begin
            b.div = 3'd6; b.rc = 6'd1;
        end
        return b;
    endfunction

endpackage

[design/fpd_cfg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpd_cfg: configuration register bank
// Decodes the write port into the reference clock, channel spacing,
// doubler and halver settings.
// ---------------------------------------------------------------------------
module fpd_cfg
    import fpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CDAT_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_clock_hz       <= RST_REF_CLOCK;
            r_cfg.channel_spacing_hz <= RST_SPACING;
            r_cfg.ref_doubler        <= RST_DOUBLER;
            r_cfg.ref_halve          <= RST_HALVE;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_REF_CLOCK: r_cfg.ref_clock_hz       <= i_cfg_data[CLK_W-1:0];
                REG_SPACING:   r_cfg.channel_spacing_hz <= i_cfg_data[SPC_W-1:0];
                REG_DOUBLER:   r_cfg.ref_doubler        <= i_cfg_data[0];
                REG_HALVE:     r_cfg.ref_halve          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/fpd_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpd_div: shared restoring divider
// Produces one quotient bit per cycle; the operands are latched on start
// and done pulses for one cycle when quotient and remainder are ready.
// ---------------------------------------------------------------------------
module fpd_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 29
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0] w_trial;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

[design/fracn_pll_divider_calc.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fracn_pll_divider_calc: fractional-N PLL divider value calculator
// Band selection, modulus scaling, integer and fractional divide values and
// reduction of fraction and modulus by their greatest common divisor.
// ---------------------------------------------------------------------------
// One frequency beat is taken at a time and o_in_stall stays high until its
// result has been placed in the output register. All divisions run through a
// single restoring divider of DVD_W = max(38, 29 + MODULUS_BITS) bits; up to
// six divisions are made per beat, besides the modulus scaling and the binary
// GCD steps. A zero channel spacing skips all but the integer division, and a
// beat also waits while its result is held off by a stalled output.
// Configuration is held in registers and may be written whenever the block
// is idle.
module fracn_pll_divider_calc
    import fpd_pkg::*;
#(
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wen,
    input  logic [CIDX_W-1:0]       i_cfg_index,
    input  logic [CDAT_W-1:0]       i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [FREQ_W-1:0]       i_freq_tenth_hz,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [DIV_W-1:0]        o_divider_select,
    output logic [RC_W-1:0]         o_r_count,
    output logic [MODULUS_BITS-1:0] o_modulus,
    output logic [INT_W-1:0]        o_integer_value,
    output logic [MODULUS_BITS-1:0] o_fraction,
    output logic [STAT_W-1:0]       o_status
);

    localparam int MB     = MODULUS_BITS;
    localparam int PROD_W = PFD_W + MB;
    localparam int DVD_W  = (PROD_W > VCO_W) ? PROD_W : VCO_W;
    localparam int K_W    = $clog2(MB + 1);
    localparam int VF_W   = F10_W + 6;
    localparam int VP_W   = F10_W + 12;

    localparam logic [CLK_W-1:0] MOD_HALF = CLK_W'(1) << (MB - 1);
    localparam logic [CLK_W-1:0] MOD_TOP  = CLK_W'(1) << MB;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_Q1S  = 5'd1;
    localparam logic [4:0] S_Q1W  = 5'd2;
    localparam logic [4:0] S_RCS  = 5'd3;
    localparam logic [4:0] S_RCW  = 5'd4;
    localparam logic [4:0] S_SCL  = 5'd5;
    localparam logic [4:0] S_VCO  = 5'd6;
    localparam logic [4:0] S_IS   = 5'd7;
    localparam logic [4:0] S_IW   = 5'd8;
    localparam logic [4:0] S_FM   = 5'd9;
    localparam logic [4:0] S_FS   = 5'd10;
    localparam logic [4:0] S_FW   = 5'd11;
    localparam logic [4:0] S_GI   = 5'd12;
    localparam logic [4:0] S_GCD  = 5'd13;
    localparam logic [4:0] S_GMS  = 5'd14;
    localparam logic [4:0] S_GMW  = 5'd15;
    localparam logic [4:0] S_GFS  = 5'd16;
    localparam logic [4:0] S_GFW  = 5'd17;
    localparam logic [4:0] S_FIN  = 5'd18;

    t_cfg w_cfg;
    t_band w_band;

    logic [4:0]        r_state;
    logic [DIV_W-1:0]  r_div;
    logic [RC_W-1:0]   r_rc;
    logic [F10_W-1:0]  r_f10;
    logic [CLK_W-1:0]  r_m;
    logic              r_modz;
    logic [PFD_W-1:0]  r_pfd;
    logic [VCO_W-1:0]  r_vco;
    logic [VCO_W-1:0]  r_integ;
    logic [PFD_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_prod;
    logic [MB-1:0]     r_frac;
    logic [MB-1:0]     r_ga;
    logic [MB-1:0]     r_gb;
    logic [K_W-1:0]    r_gk;
    logic [MB-1:0]     r_g;

    logic                r_out_valid;
    logic [DIV_W-1:0]    r_o_div;
    logic [RC_W-1:0]     r_o_rc;
    logic [MB-1:0]       r_o_mod;
    logic [INT_W-1:0]    r_o_int;
    logic [MB-1:0]       r_o_frac;
    logic [STAT_W-1:0]   r_o_stat;

    logic              w_div_start;
    logic [DVD_W-1:0]  w_dvd;
    logic [PFD_W-1:0]  w_dvs;
    logic              w_div_done;
    logic [DVD_W-1:0]  w_quot;
    logic [PFD_W-1:0]  w_drem;

    logic [PFD_W-1:0]  w_pfd;
    logic [VF_W-1:0]   w_f10s;
    logic [VP_W-1:0]   w_vco_full;
    logic              w_accept;
    logic              w_out_free;
    logic              w_sat;

    fpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fpd_div #(
        .DVD_W (DVD_W),
        .DVS_W (PFD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    assign w_band     = band_sel(i_freq_tenth_hz);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_sat      = |r_integ[VCO_W-1:INT_W];

    assign w_pfd      = ({1'b0, w_cfg.ref_clock_hz} << w_cfg.ref_doubler) >> w_cfg.ref_halve;
    assign w_f10s     = VF_W'(r_f10) << r_div;
    assign w_vco_full = VP_W'(w_f10s) * VP_W'(r_rc);

    // Operand selection for the shared divider, one source per start state.
    always_comb begin
        w_div_start = 1'b0;
        w_dvd       = '0;
        w_dvs       = '0;
        case (r_state)
            S_Q1S: begin
                w_div_start = (w_cfg.channel_spacing_hz != '0);
                w_dvd       = DVD_W'(w_cfg.ref_clock_hz);
                w_dvs       = PFD_W'(w_cfg.channel_spacing_hz);
            end
            S_RCS: begin
                w_div_start = 1'b1;
                w_dvd       = DVD_W'(r_m);
                w_dvs       = PFD_W'(r_rc);
            end
            S_IS: begin
                w_div_start = (r_pfd != '0);
                w_dvd       = DVD_W'(r_vco);
                w_dvs       = r_pfd;
            end
            S_FS: begin
                w_div_start = 1'b1;
                w_dvd       = DVD_W'(r_prod);
                w_dvs       = r_pfd;
            end
            S_GMS: begin
                w_div_start = 1'b1;
                w_dvd       = DVD_W'(r_m[MB-1:0]);
                w_dvs       = PFD_W'(r_g);
            end
            S_GFS: begin
                w_div_start = 1'b1;
                w_dvd       = DVD_W'(r_frac);
                w_dvs       = PFD_W'(r_g);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_Q1S;
                    end
                end
                S_Q1S: begin
                    r_state <= (w_cfg.channel_spacing_hz != '0) ? S_Q1W : S_SCL;
                end
                S_Q1W: begin
                    if (w_div_done) begin
                        r_state <= S_RCS;
                    end
                end
                S_RCS: r_state <= S_RCW;
                S_RCW: begin
                    if (w_div_done) begin
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    if ((r_m == '0) || ((r_m >= MOD_HALF) && (r_m < MOD_TOP))) begin
                        r_state <= S_VCO;
                    end
                end
                S_VCO: r_state <= S_IS;
                S_IS:  r_state <= (r_pfd != '0) ? S_IW : S_GI;
                S_IW: begin
                    if (w_div_done) begin
                        r_state <= S_FM;
                    end
                end
                S_FM:  r_state <= r_modz ? S_GI : S_FS;
                S_FS:  r_state <= S_FW;
                S_FW: begin
                    if (w_div_done) begin
                        r_state <= S_GI;
                    end
                end
                S_GI: begin
                    r_state <= (r_modz || (r_frac == '0)) ? S_FIN : S_GCD;
                end
                S_GCD: begin
                    if ((r_ga == '0) || (r_gb == '0)) begin
                        r_state <= S_GMS;
                    end
                end
                S_GMS: r_state <= S_GMW;
                S_GMW: begin
                    if (w_div_done) begin
                        r_state <= S_GFS;
                    end
                end
                S_GFS: r_state <= S_GFW;
                S_GFW: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, updated according to the sequencer state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_div  <= w_band.div;
                    r_rc   <= w_band.rc;
                    r_f10  <= (F10_W'(i_freq_tenth_hz) << 3) + (F10_W'(i_freq_tenth_hz) << 1);
                    r_modz <= 1'b0;
                    r_frac <= '0;
                end
            end
            S_Q1S: begin
                if (w_cfg.channel_spacing_hz == '0) begin
                    r_m <= '0;
                end
            end
            S_Q1W: begin
                if (w_div_done) begin
                    r_m <= (w_cfg.ref_doubler ? w_quot[CLK_W-1:0] : '0) >> r_div;
                end
            end
            S_RCW: begin
                if (w_div_done) begin
                    r_m <= w_quot[CLK_W-1:0];
                end
            end
            S_SCL: begin
                // A nonzero modulus is walked one bit a cycle into [2^(MB-1), 2^MB).
                if (r_m == '0) begin
                    r_modz <= 1'b1;
                end else if (r_m < MOD_HALF) begin
                    r_m <= r_m << 1;
                end else if (r_m >= MOD_TOP) begin
                    r_m <= r_m >> 1;
                end
            end
            S_VCO: begin
                r_pfd <= w_pfd;
                r_vco <= w_vco_full[VCO_W-1:0];
            end
            S_IS: begin
                if (r_pfd == '0) begin
                    r_integ <= '0;
                end
            end
            S_IW: begin
                if (w_div_done) begin
                    r_integ <= w_quot[VCO_W-1:0];
                    r_rem   <= w_drem;
                end
            end
            S_FM: begin
                r_prod <= PROD_W'(r_rem) * PROD_W'(r_m[MB-1:0]);
            end
            S_FW: begin
                if (w_div_done) begin
                    r_frac <= w_quot[MB-1:0];
                end
            end
            S_GI: begin
                // A zero fraction reduces the modulus to one.
                if (!r_modz && (r_frac == '0)) begin
                    r_m <= CLK_W'(1);
                end
                r_ga <= r_m[MB-1:0];
                r_gb <= r_frac;
                r_gk <= '0;
            end
            S_GCD: begin
                // Binary GCD: common factors of two are counted in r_gk.
                if (r_ga == '0) begin
                    r_g <= r_gb << r_gk;
                end else if (r_gb == '0) begin
                    r_g <= r_ga << r_gk;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1;
                    r_gb <= r_gb >> 1;
                    r_gk <= r_gk + 1'b1;
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else if (!r_gb[0]) begin
                    r_gb <= r_gb >> 1;
                end else if (r_ga >= r_gb) begin
                    r_ga <= r_ga - r_gb;
                end else begin
                    r_gb <= r_gb - r_ga;
                end
            end
            S_GMW: begin
                if (w_div_done) begin
                    r_m <= CLK_W'(w_quot[MB-1:0]);
                end
            end
            S_GFW: begin
                if (w_div_done) begin
                    r_frac <= w_quot[MB-1:0];
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_o_div  <= r_div;
                    r_o_rc   <= r_rc;
                    r_o_mod  <= r_modz ? '0 : r_m[MB-1:0];
                    r_o_int  <= w_sat ? INT_MAX : r_integ[INT_W-1:0];
                    r_o_frac <= r_frac;
                    if (r_modz) begin
                        r_o_stat <= ST_ZERO_MOD;
                    end else if (w_sat) begin
                        r_o_stat <= ST_INT_SAT;
                    end else begin
                        r_o_stat <= ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_divider_select = r_o_div;
    assign o_r_count        = r_o_rc;
    assign o_modulus        = r_o_mod;
    assign o_integer_value  = r_o_int;
    assign o_fraction       = r_o_frac;
    assign o_status         = r_o_stat;

endmodule

[dv/divider_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// divider_result_checker: divider setting predictor and result comparison
// Follows the register writes and the frequency beats of the divider
// calculator, predicts the divider setting for every accepted frequency and
// compares each accepted result beat, field by field, with the oldest one.
// ---------------------------------------------------------------------------
module divider_result_checker
    import fpd_pkg::*;
#(
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wen,
    input  logic [CIDX_W-1:0]       i_cfg_index,
    input  logic [CDAT_W-1:0]       i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [FREQ_W-1:0]       i_freq_tenth_hz,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [DIV_W-1:0]        i_divider_select,
    input  logic [RC_W-1:0]         i_r_count,
    input  logic [MODULUS_BITS-1:0] i_modulus,
    input  logic [INT_W-1:0]        i_integer_value,
    input  logic [MODULUS_BITS-1:0] i_fraction,
    input  logic [STAT_W-1:0]       i_status,
    output int unsigned             o_fail_count,
    output int unsigned             o_pending
);

    localparam longint unsigned MOD_TOP  = 64'd1 << MODULUS_BITS;
    localparam longint unsigned MOD_HALF = MOD_TOP >> 1;
    localparam int unsigned     REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DIV_W-1:0]        divider_select;
        logic [RC_W-1:0]         r_count;
        logic [MODULUS_BITS-1:0] modulus;
        logic [INT_W-1:0]        integer_value;
        logic [MODULUS_BITS-1:0] fraction;
        logic [STAT_W-1:0]       status;
    } t_divider_setting;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        t_divider_setting  setting;
    } t_awaited;

    t_cfg        regs;
    t_awaited    awaited_settings[$];
    int unsigned mismatches = 0;

    function automatic t_divider_setting calc_divider_setting(input logic [FREQ_W-1:0] freq,
                                                              input t_cfg c);
        t_divider_setting r;
        longint unsigned  dsel, rcnt, mod_val, pfd, vco, quot, frac, a, b, t;
        logic [STAT_W-1:0] st;
        // Each band limit is the top one halved; the lowest band catches the rest.
        dsel = 6;
        for (int k = 5; k >= 0; k--) begin
            if (freq > (BAND_LIM0 >> k)) dsel = longint'(k);
        end
        case (dsel)
            0: rcnt = 50;
            1: rcnt = 25;
            2: rcnt = 16;
            3: rcnt = 8;
            4: rcnt = 4;
            5: rcnt = 2;
            default: rcnt = 1;
        endcase
        st = ST_OK;
        frac = 0;
        quot = 0;
        if (c.channel_spacing_hz == '0) begin
            mod_val = 0;
        end else begin
            mod_val = (((64'(c.ref_clock_hz) / 64'(c.channel_spacing_hz))
                        * 64'(c.ref_doubler)) >> dsel) / rcnt;
        end
        if (mod_val != 0) begin
            while (mod_val < MOD_HALF) mod_val = mod_val << 1;
            while (mod_val >= MOD_TOP) mod_val = mod_val >> 1;
        end else begin
            st = ST_ZERO_MOD;
        end
        pfd = (64'(c.ref_clock_hz) << c.ref_doubler) >> c.ref_halve;
        vco = ((64'(freq) * 64'd10) << dsel) * rcnt;
        if (pfd != 0) begin
            quot = vco / pfd;
            if (mod_val != 0) frac = ((vco % pfd) * mod_val) / pfd;
        end
        if (quot > 64'(INT_MAX)) begin
            quot = 64'(INT_MAX);
            if (st == ST_OK) st = ST_INT_SAT;
        end
        // Reduce fraction and modulus together; a zero fraction leaves a modulus of one.
        if (mod_val != 0) begin
            a = mod_val;
            b = frac;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            mod_val = mod_val / a;
            frac = frac / a;
        end
        r.divider_select = DIV_W'(dsel);
        r.r_count        = RC_W'(rcnt);
        r.modulus        = MODULUS_BITS'(mod_val);
        r.integer_value  = INT_W'(quot);
        r.fraction       = MODULUS_BITS'(frac);
        r.status         = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_awaited         want;
        t_divider_setting got;
        logic             bad;
        if (!i_rst_n) begin
            regs = {RST_REF_CLOCK, RST_SPACING, RST_DOUBLER, RST_HALVE};
            awaited_settings.delete();
        end else begin
            // Results always leave after their frequency is accepted, so retire first.
            if (i_out_valid && !i_out_stall) begin
                got = {i_divider_select, i_r_count, i_modulus, i_integer_value,
                       i_fraction, i_status};
                if (awaited_settings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result beat with nothing outstanding: div %0d rc %0d",
                                 $time, got.divider_select, got.r_count);
                        $display("    mod %0d int %0d frac %0d status %0d",
                                 got.modulus, got.integer_value, got.fraction, got.status);
                    end
                end else begin
                    want = awaited_settings.pop_front();
                    bad = (got.divider_select !== want.setting.divider_select)
                        | (got.r_count !== want.setting.r_count)
                        | (got.modulus !== want.setting.modulus)
                        | (got.integer_value !== want.setting.integer_value)
                        | (got.fraction !== want.setting.fraction)
                        | (got.status !== want.setting.status);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch for freq %0d, expected div %0d rc %0d",
                                     $time, want.freq, want.setting.divider_select,
                                     want.setting.r_count);
                            $display("    mod %0d int %0d frac %0d status %0d",
                                     want.setting.modulus, want.setting.integer_value,
                                     want.setting.fraction, want.setting.status);
                            $display("    got div %0d rc %0d mod %0d int %0d frac %0d status %0d",
                                     got.divider_select, got.r_count, got.modulus,
                                     got.integer_value, got.fraction, got.status);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want.freq = i_freq_tenth_hz;
                want.setting = calc_divider_setting(i_freq_tenth_hz, regs);
                awaited_settings.push_back(want);
            end
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    REG_REF_CLOCK: regs.ref_clock_hz = i_cfg_data[CLK_W-1:0];
                    REG_SPACING:   regs.channel_spacing_hz = i_cfg_data[SPC_W-1:0];
                    REG_DOUBLER:   regs.ref_doubler = i_cfg_data[0];
                    REG_HALVE:     regs.ref_halve = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending <= awaited_settings.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: fractional-N divider calculator
// Drives frequency beats under several register settings, first directed at
// band edges, zero modulus, zero rate and saturation, then random, with
// random gaps on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;
    import fpd_pkg::*;

    localparam int MOD_BITS        = MODULUS_BITS_DEF;
    localparam int DRAIN_CYCLES    = 800;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int QUIET_LIMIT     = 20000;
    localparam int RANDOM_PHASES   = 10;
    localparam int BEATS_PER_PHASE = 125;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wen = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDAT_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FREQ_W-1:0]   freq = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DIV_W-1:0]    divider_select;
    logic [RC_W-1:0]     r_count;
    logic [MOD_BITS-1:0] modulus;
    logic [INT_W-1:0]    integer_value;
    logic [MOD_BITS-1:0] fraction;
    logic [STAT_W-1:0]   status;
    int unsigned         fail_count;
    int unsigned         pending;
    int unsigned         quiet_cycles = 0;
    bit                  idle_on = 1'b1;
    bit                  hold_off_req = 1'b0;

    always #2 clk = ~clk;

    fracn_pll_divider_calc #(
        .MODULUS_BITS(MOD_BITS)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wen        (cfg_wen),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_freq_tenth_hz  (freq),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_divider_select (divider_select),
        .o_r_count        (r_count),
        .o_modulus        (modulus),
        .o_integer_value  (integer_value),
        .o_fraction       (fraction),
        .o_status         (status)
    );

    divider_result_checker #(
        .MODULUS_BITS(MOD_BITS)
    ) results_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wen        (cfg_wen),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_freq_tenth_hz  (freq),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_divider_select (divider_select),
        .i_r_count        (r_count),
        .i_modulus        (modulus),
        .i_integer_value  (integer_value),
        .i_fraction       (fraction),
        .i_status         (status),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // A run that stops moving beats on either channel is declared hung.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stall bursts, free-running stretches and one long hold-off.
    initial begin
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic offer_freq(input logic [FREQ_W-1:0] f);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        freq <= f;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Waits for every outstanding result, then gives the block time to settle.
    task automatic drain_block;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers; unused upper data bits may carry noise.
    task automatic load_settings(input t_cfg s, input bit noisy);
        logic [CDAT_W-1:0] junk;
        junk = noisy ? CDAT_W'($urandom) : '0;
        cfg_wen <= 1'b1;
        cfg_index <= REG_REF_CLOCK;
        cfg_data <= CDAT_W'(s.ref_clock_hz);
        @(posedge clk);
        cfg_index <= REG_SPACING;
        cfg_data <= {junk[CDAT_W-1:SPC_W], s.channel_spacing_hz};
        @(posedge clk);
        cfg_index <= REG_DOUBLER;
        cfg_data <= {junk[CDAT_W-1:1], s.ref_doubler};
        @(posedge clk);
        cfg_index <= REG_HALVE;
        cfg_data <= {junk[CDAT_W-1:1], s.ref_halve};
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic check_one(input t_cfg s, input logic [FREQ_W-1:0] f);
        load_settings(s, 1'b0);
        offer_freq(f);
        drain_block();
    endtask

    function automatic t_cfg random_settings();
        t_cfg s;
        if ($urandom_range(0, 4) == 0) begin
            s = {CLK_W'($urandom), SPC_W'($urandom), 1'($urandom), 1'($urandom)};
        end else begin
            s.ref_clock_hz = CLK_W'($urandom_range(1000000, 250000000));
            s.channel_spacing_hz = ($urandom_range(0, 1) == 0)
                                 ? SPC_W'($urandom_range(1, 1000000))
                                 : SPC_W'($urandom_range(1, 5000));
            s.ref_doubler = ($urandom_range(0, 7) != 0);
            s.ref_halve = 1'($urandom_range(0, 1));
        end
        return s;
    endfunction

    function automatic logic [FREQ_W-1:0] random_freq();
        logic [FREQ_W-1:0] f;
        int unsigned       band, lo, hi, limit_f;
        case ($urandom_range(0, 9))
            0: f = FREQ_W'($urandom);
            1: begin
                limit_f = 32'(BAND_LIM0) >> $urandom_range(0, 5);
                f = FREQ_W'(limit_f + $urandom_range(0, 2) - 1);
            end
            default: begin
                band = $urandom_range(0, 6);
                hi = (band == 0) ? 440000000 : (32'(BAND_LIM0) >> (band - 1));
                lo = (band == 6) ? 0 : (32'(BAND_LIM0) >> band) + 1;
                f = FREQ_W'($urandom_range(lo, hi));
            end
        endcase
        return f;
    endfunction

    initial begin
        t_cfg s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, a whole-number divide and both sides of each band edge.
        offer_freq('0);
        offer_freq(29'd1);
        offer_freq(29'd2000000);
        for (int b = 0; b < 6; b++) begin
            offer_freq(BAND_LIM0 >> b);
            offer_freq((BAND_LIM0 >> b) + 29'd1);
        end
        offer_freq(29'd440000000);
        offer_freq('1);
        drain_block();

        // Doubler off, zero spacing, zero phase detector rate and zero reference clock.
        check_one({28'd10000000, 20'd100, 1'b0, 1'b0}, 29'd100000000);
        check_one({28'd10000000, 20'd0, 1'b1, 1'b0}, 29'd300000000);
        check_one({28'd1, 20'd100, 1'b0, 1'b1}, 29'd50000000);
        check_one({28'd0, 20'd1, 1'b1, 1'b1}, 29'd20000000);
        // Saturated integer value, alone and together with a zero modulus.
        check_one({28'd1000, 20'd1, 1'b1, 1'b1}, 29'd300000000);
        check_one({28'd1000, 20'd1, 1'b1, 1'b1}, '1);
        check_one({28'd1000, 20'd1000000, 1'b1, 1'b0}, 29'd200000000);
        // Widest registers, and a raw modulus far above range that must be halved.
        check_one({28'hFFFFFFF, 20'hFFFFF, 1'b1, 1'b1}, 29'd3000000);
        check_one({28'hFFFFFFF, 20'd1, 1'b1, 1'b0}, 29'd5000000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s = random_settings();
            if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
            load_settings(s, 1'b1);
            if (p == 1) hold_off_req = 1'b1;
            repeat (BEATS_PER_PHASE) offer_freq(random_freq());
            drain_block();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
